@@ rtl/core/fsq_pkg.sv @@
package fsq_pkg;

	// Block dimensions
	localparam int MODEL_WIDTH = 512;
	localparam int CW          = $clog2(MODEL_WIDTH);
	localparam int MAX_FRAMES  = 1024;
	localparam int FW          = $clog2(MAX_FRAMES);
	localparam int MAX_LOGITS  = 64;
	localparam int LW          = $clog2(MAX_LOGITS);
	localparam int LEVEL_COUNT = 4;
	localparam int LVW         = 2;
	localparam int OFF_W       = 7;

	// Field widths
	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 32;
	localparam int POS_W      = 12;
	localparam int TOKEN_W    = 16;
	localparam int FRAMES_W   = 11;
	localparam int TOKENS_W   = 13;
	localparam int LEVEL_W    = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// Pass sequencing
	localparam int LIDX_W      = LW + CW;
	localparam int PASS_W      = LIDX_W + 1;
	localparam int LOGIT_ITEMS = MAX_LOGITS * MODEL_WIDTH;
	localparam int DRAIN       = 6;

	// Word kinds
	localparam logic [1:0] KIND_TABLE = 2'd0;
	localparam logic [1:0] KIND_FRAME = 2'd1;
	localparam logic [1:0] KIND_TOKEN = 2'd2;

	// Table selects
	localparam logic [1:0] SEL_GAIN   = 2'd0;
	localparam logic [1:0] SEL_OFFSET = 2'd1;
	localparam logic [1:0] SEL_BIAS   = 2'd2;
	localparam logic [1:0] SEL_WEIGHT = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOKENS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL3 = 3'd5;

	typedef enum logic [4:0] {
		ST_IDLE, ST_POS, ST_QDIV, ST_WSTART, ST_WDIV, ST_CLAMP,
		ST_BLEND, ST_VAR, ST_VSTART, ST_VDIV, ST_SSTART, ST_SQRT,
		ST_NORM, ST_LOGIT, ST_ARG_RD, ST_ARG_CMP, ST_LVL_END, ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PASS_BLEND, PASS_VAR, PASS_NORM, PASS_LOGIT
	} pass_t;

	typedef struct packed {
		logic              load_pos;
		logic              pos_start;
		logic              w_start;
		logic              latch_w;
		logic              clamp;
		logic              var_start;
		logic              sqrt_start;
		logic              latch_inv;
		logic              issue;
		pass_t             pass_op;
		logic [LIDX_W-1:0] idx;
		logic              arg_rd;
		logic              arg_cmp;
		logic [4:0]        arg_i;
		logic [OFF_W-1:0]  arg_idx;
		logic              arg_lvl_end;
		logic [LVW-1:0]    lv;
		logic              emit;
	} cmd_t;

	typedef struct packed {
		logic               num_pos;
		logic               div_done;
		logic               div_busy;
		logic               sqrt_done;
		logic               sqrt_busy;
		logic               out_busy;
		logic [LEVEL_W-1:0] level_size;
	} status_t;

endpackage

@@ rtl/core/interpolating_fsq_token_head.sv @@
// Token head: table and frame words are written to memory as they are
// accepted; a token request resamples two stored frames, layer-normalizes
// the blend, runs the 64-row linear head and packs the per-digit arg-maxes
// into one word. A request runs up to two 64-step divides for the source
// position, three 512-channel passes, a 64-step divide and a 32-step square
// root for the inverse deviation, then the head, one multiply-accumulate per
// cycle set by the single read port of the weight memory, and last the
// arg-max, which reads and then compares each logit examined in turn.
// Requests are taken one at a time; new words are accepted
// while a finished token waits on the output.
module interpolating_fsq_token_head (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fsq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// row_index[9:0], column_index[18:10], word_value[50:19], token_position[62:51]
	input  logic [fsq_pkg::IN_DATA_W-1:0]  s_tdata,
	// kind[1:0], table_select[3:2]
	input  logic [fsq_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// token_code[15:0], echoed_position[27:16]
	output logic [fsq_pkg::OUT_DATA_W-1:0] m_tdata
);
	import fsq_pkg::*;

	cmd_t    cmd;
	status_t st;
	logic    s_accept;

	assign s_accept = s_tvalid && s_tready;

	fsq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_kind   (s_tuser[1:0]),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	fsq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_accept  (s_accept),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.st        (st)
	);

	// a token request leaves the input stalled while it runs
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_tuser[1:0] == KIND_TOKEN) |=> !s_tready)
		else $error("input not stalled after token request");

	// divider and root unit are never active together
	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(st.div_busy && st.sqrt_busy))
		else $error("divider and root unit overlap");

	// a result appears only from the controller's emit
	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.emit))
		else $error("result without emit");

	// emit never overwrites a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(m_tvalid && !m_tready))
		else $error("pending result overwritten");
endmodule

@@ rtl/core/fsq_div.sv @@
module fsq_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [63:0] quotient,
	output logic [63:0] remainder
);
	logic [6:0]  cnt_q;
	logic        busy_q, done_q;
	logic [63:0] rem_q, quo_q, dsr_q;
	logic [64:0] shifted;
	logic [65:0] trial;

	// one restoring step per cycle
	assign shifted = {rem_q, quo_q[63]};
	assign trial   = {1'b0, shifted} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= 7'd64;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[65]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

@@ rtl/core/fsq_isqrt.sv @@
module fsq_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic        done,
	output logic [63:0] root
);
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [63:0] x_q, r_q, bit_q;
	logic [63:0] trial;

	// digit-by-digit root, one result bit per cycle
	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= 6'd32;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q <= x_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = r_q;
endmodule

@@ rtl/core/fsq_ctrl.sv @@
module fsq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic [1:0]      s_kind,
	output logic            s_tready,
	input  fsq_pkg::status_t st,
	output fsq_pkg::cmd_t   cmd
);
	import fsq_pkg::*;

	state_t           state_q, state_d;
	logic [PASS_W-1:0] cnt_q;
	logic [LVW-1:0]   lv_q;
	logic [4:0]       i_q;
	logic [OFF_W-1:0] off_q;
	logic [OFF_W-1:0] arg_idx;
	logic             in_pass, pass_last, arg_skip;
	int               items;

	// pass length bookkeeping
	always_comb begin
		items     = (state_q == ST_LOGIT) ? LOGIT_ITEMS : MODEL_WIDTH;
		in_pass   = (state_q == ST_BLEND) || (state_q == ST_VAR) ||
		            (state_q == ST_NORM) || (state_q == ST_LOGIT);
		pass_last = (cnt_q == PASS_W'(items + DRAIN - 1));
		arg_idx   = off_q + OFF_W'(i_q);
		arg_skip  = (i_q == st.level_size) || (arg_idx >= OFF_W'(MAX_LOGITS));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (s_tvalid && s_kind == KIND_TOKEN) state_d = ST_POS;
			ST_POS:     state_d = st.num_pos ? ST_QDIV : ST_CLAMP;
			ST_QDIV:    if (st.div_done) state_d = ST_WSTART;
			ST_WSTART:  state_d = ST_WDIV;
			ST_WDIV:    if (st.div_done) state_d = ST_CLAMP;
			ST_CLAMP:   state_d = ST_BLEND;
			ST_BLEND:   if (pass_last) state_d = ST_VAR;
			ST_VAR:     if (pass_last) state_d = ST_VSTART;
			ST_VSTART:  state_d = ST_VDIV;
			ST_VDIV:    if (st.div_done) state_d = ST_SSTART;
			ST_SSTART:  state_d = ST_SQRT;
			ST_SQRT:    if (st.sqrt_done) state_d = ST_NORM;
			ST_NORM:    if (pass_last) state_d = ST_LOGIT;
			ST_LOGIT:   if (pass_last) state_d = ST_ARG_RD;
			ST_ARG_RD:  state_d = arg_skip ? ST_LVL_END : ST_ARG_CMP;
			ST_ARG_CMP: state_d = ST_ARG_RD;
			ST_LVL_END: state_d = (lv_q == LVW'(LEVEL_COUNT - 1)) ? ST_DONE : ST_ARG_RD;
			ST_DONE:    if (!st.out_busy) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd         = '0;
		cmd.idx     = cnt_q[LIDX_W-1:0];
		cmd.arg_i   = i_q;
		cmd.arg_idx = arg_idx;
		cmd.lv      = lv_q;
		cmd.pass_op = PASS_BLEND;
		s_tready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready     = 1'b1;
				cmd.load_pos = s_tvalid && s_kind == KIND_TOKEN;
			end
			ST_POS:     cmd.pos_start  = st.num_pos;
			ST_WSTART:  cmd.w_start    = 1'b1;
			ST_WDIV:    cmd.latch_w    = st.div_done;
			ST_CLAMP:   cmd.clamp      = 1'b1;
			ST_BLEND: begin
				cmd.pass_op = PASS_BLEND;
				cmd.issue   = cnt_q < PASS_W'(MODEL_WIDTH);
			end
			ST_VAR: begin
				cmd.pass_op = PASS_VAR;
				cmd.issue   = cnt_q < PASS_W'(MODEL_WIDTH);
			end
			ST_VSTART:  cmd.var_start  = 1'b1;
			ST_SSTART:  cmd.sqrt_start = 1'b1;
			ST_SQRT:    cmd.latch_inv  = st.sqrt_done;
			ST_NORM: begin
				cmd.pass_op = PASS_NORM;
				cmd.issue   = cnt_q < PASS_W'(MODEL_WIDTH);
			end
			ST_LOGIT: begin
				cmd.pass_op = PASS_LOGIT;
				cmd.issue   = cnt_q < PASS_W'(LOGIT_ITEMS);
			end
			ST_ARG_RD:  cmd.arg_rd      = !arg_skip;
			ST_ARG_CMP: cmd.arg_cmp     = 1'b1;
			ST_LVL_END: cmd.arg_lvl_end = 1'b1;
			ST_DONE:    cmd.emit        = !st.out_busy;
			default: ;
		endcase
	end

	// state and sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			lv_q    <= '0;
			i_q     <= '0;
			off_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else if (in_pass) cnt_q <= cnt_q + PASS_W'(1);
			case (state_q)
				ST_IDLE: begin
					lv_q  <= '0;
					i_q   <= '0;
					off_q <= '0;
				end
				ST_ARG_CMP: i_q <= i_q + 5'd1;
				ST_LVL_END: begin
					i_q   <= '0;
					lv_q  <= lv_q + LVW'(1);
					off_q <= off_q + OFF_W'(st.level_size);
				end
				default: ;
			endcase
		end
	end
endmodule

@@ rtl/core/fsq_dp.sv @@
module fsq_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fsq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fsq_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_accept,
	input  logic [fsq_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [fsq_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fsq_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  fsq_pkg::cmd_t                   cmd,
	output fsq_pkg::status_t                st
);
	import fsq_pkg::*;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) r = 32'sh7fff_ffff;
		else if (x < -64'sd2147483648) r = 32'sh8000_0000;
		else r = x[31:0];
		return r;
	endfunction

	// input word fields
	logic [1:0]         in_kind, in_sel;
	logic [9:0]         in_row;
	logic [8:0]         in_col;
	logic signed [31:0] in_word;
	logic [POS_W-1:0]   in_pos;
	assign in_kind = s_tuser[1:0];
	assign in_sel  = s_tuser[3:2];
	assign in_row  = s_tdata[9:0];
	assign in_col  = s_tdata[18:10];
	assign in_word = s_tdata[50:19];
	assign in_pos  = s_tdata[62:51];

	// configuration registers
	logic [FRAMES_W-1:0] frames_q;
	logic [TOKENS_W-1:0] tokens_q;
	logic [LEVEL_W-1:0]  level_q [LEVEL_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_W'(1);
			tokens_q <= TOKENS_W'(1);
			for (int k = 0; k < LEVEL_COUNT; k++) level_q[k] <= LEVEL_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAMES: frames_q <= cfg_data[FRAMES_W-1:0];
				CFG_TOKENS: tokens_q <= cfg_data[TOKENS_W-1:0];
				CFG_LEVEL0, CFG_LEVEL1, CFG_LEVEL2, CFG_LEVEL3: begin
					if (int'(cfg_index - CFG_LEVEL0) < LEVEL_COUNT)
						level_q[LVW'(cfg_index - CFG_LEVEL0)] <= cfg_data[LEVEL_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// effective register values
	logic [FRAMES_W-1:0] eff_s;
	logic [FW-1:0]       s_m1;
	logic [TOKENS_W-1:0] eff_n;
	logic [LEVEL_W-1:0]  raw_lvl, eff_lvl;
	always_comb begin
		if (frames_q == '0) eff_s = FRAMES_W'(1);
		else if (frames_q > FRAMES_W'(MAX_FRAMES)) eff_s = FRAMES_W'(MAX_FRAMES);
		else eff_s = frames_q;
		s_m1    = FW'(eff_s - FRAMES_W'(1));
		eff_n   = (tokens_q == '0) ? TOKENS_W'(1) : tokens_q;
		raw_lvl = level_q[cmd.lv];
		if (raw_lvl == '0) eff_lvl = LEVEL_W'(1);
		else if (raw_lvl > LEVEL_W'(16)) eff_lvl = LEVEL_W'(16);
		else eff_lvl = raw_lvl;
	end

	// memories
	logic signed [31:0] frame_mem [MAX_FRAMES*MODEL_WIDTH];
	logic signed [31:0] gain_mem  [MODEL_WIDTH];
	logic signed [31:0] off_mem   [MODEL_WIDTH];
	logic signed [31:0] bias_mem  [MAX_LOGITS];
	logic signed [31:0] wt_mem    [MAX_LOGITS*MODEL_WIDTH];
	logic signed [31:0] blend_mem [MODEL_WIDTH];
	logic signed [31:0] logit_mem [MAX_LOGITS];

	logic wr_tab, wr_frame;
	assign wr_tab   = s_accept && in_kind == KIND_TABLE;
	assign wr_frame = s_accept && in_kind == KIND_FRAME &&
	                  int'(in_row) < MAX_FRAMES && int'(in_col) < MODEL_WIDTH;

	// position and resampling state
	logic [POS_W-1:0]   t_q;
	logic signed [25:0] num_q;
	logic [22:0]        left_q;
	logic [15:0]        w_q;
	logic [FW-1:0]      fleft_q, fright_q;
	logic [24:0]        inv_q;
	logic signed [40:0] sum_q;
	logic [63:0]        sumsq_q;
	logic signed [31:0] mean;
	logic [13:0]        den;

	// divider (shared) and root unit
	logic        div_start, div_busy, div_done;
	logic [63:0] div_dvd, div_dsr, div_quo, div_rem;
	logic        sq_busy, sq_done;
	logic [63:0] sq_root;

	assign mean      = 32'(sum_q >>> CW);
	assign den       = {eff_n, 1'b0};
	assign div_start = cmd.pos_start || cmd.w_start || cmd.var_start;

	always_comb begin
		div_dvd = 64'(num_q[24:0]);
		div_dsr = 64'(den);
		if (cmd.w_start) div_dvd = div_rem << 16;
		if (cmd.var_start) begin
			div_dvd = 64'd1 << 48;
			div_dsr = (sumsq_q >> CW) + 64'd1;
		end
	end

	fsq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	fsq_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (div_quo),
		.busy     (sq_busy),
		.done     (sq_done),
		.root     (sq_root)
	);

	// source position, clamp and neighbor frames
	logic [FW-1:0] lc;
	logic [FW:0]   lc_p1;
	always_comb begin
		lc    = (left_q >= 23'(s_m1)) ? s_m1 : left_q[FW-1:0];
		lc_p1 = {1'b0, lc} + (FW+1)'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pos) begin
			t_q    <= in_pos;
			num_q  <= $signed({1'b0, 25'({in_pos, 1'b1}) * 25'(eff_s)}) -
			          $signed({13'b0, eff_n});
			left_q <= '0;
			w_q    <= '0;
		end
		if (cmd.w_start) left_q <= div_quo[22:0];
		if (cmd.latch_w) w_q <= div_quo[15:0];
		if (cmd.clamp) begin
			fleft_q  <= lc;
			fright_q <= (lc_p1 < {1'b0, s_m1}) ? lc_p1[FW-1:0] : s_m1;
			if (left_q >= 23'(s_m1)) w_q <= '0;
		end
		if (cmd.latch_inv) inv_q <= sq_root[24:0];
	end

	// pass pipeline
	logic                 v_s1, v_s2, v_s3, v_s4;
	pass_t                op_s1, op_s2, op_s3, op_s4;
	logic [CW-1:0]        c_s1, c_s2, c_s3, c_s4;
	logic [LW-1:0]        d_s1, d_s2;
	logic                 first_s1, first_s2, last_s1, last_s2;
	logic signed [31:0]   fl_s1, fr_s1, bl_s1, g_s1, o_s1, wt_s1, bias_s1;
	logic signed [31:0]   fl_s2, g_s2, o_s2, bias_s2;
	logic signed [49:0]   bprod_s2;
	logic signed [32:0]   ce_s2;
	logic signed [63:0]   lp_s2;
	logic [63:0]          sq_s3;
	logic signed [58:0]   p1_s3;
	logic signed [31:0]   g_s3, o_s3, g_s4, o_s4;
	logic signed [48:0]   p2_s4;
	logic signed [26:0]   yh_s4;
	logic signed [63:0]   acc_q;
	logic signed [31:0]   lg_rd_q, best_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: memory reads
	logic [CW-1:0] rc;
	logic [LW-1:0] rd;
	assign rc = cmd.idx[CW-1:0];
	assign rd = cmd.idx[LIDX_W-1:CW];

	always_ff @(posedge clk) begin
		op_s1    <= cmd.pass_op;
		c_s1     <= rc;
		d_s1     <= rd;
		first_s1 <= rc == '0;
		last_s1  <= rc == CW'(MODEL_WIDTH - 1);
		fl_s1    <= frame_mem[{fleft_q, rc}];
		fr_s1    <= frame_mem[{fright_q, rc}];
		if (wr_frame) frame_mem[{in_row[FW-1:0], in_col[CW-1:0]}] <= in_word;
	end

	always_ff @(posedge clk) begin
		g_s1    <= gain_mem[rc];
		o_s1    <= off_mem[rc];
		bias_s1 <= bias_mem[rd];
		wt_s1   <= wt_mem[cmd.idx];
		if (wr_tab && in_sel == SEL_GAIN && int'(in_col) < MODEL_WIDTH)
			gain_mem[in_col[CW-1:0]] <= in_word;
		if (wr_tab && in_sel == SEL_OFFSET && int'(in_col) < MODEL_WIDTH)
			off_mem[in_col[CW-1:0]] <= in_word;
		if (wr_tab && in_sel == SEL_BIAS && int'(in_row) < MAX_LOGITS)
			bias_mem[in_row[LW-1:0]] <= in_word;
		if (wr_tab && in_sel == SEL_WEIGHT && int'(in_row) < MAX_LOGITS &&
		    int'(in_col) < MODEL_WIDTH)
			wt_mem[{in_row[LW-1:0], in_col[CW-1:0]}] <= in_word;
	end

	// stage 2: first multiply or centering
	logic signed [32:0] diff_s1;
	assign diff_s1 = $signed({fr_s1[31], fr_s1}) - $signed({fl_s1[31], fl_s1});

	always_ff @(posedge clk) begin
		op_s2    <= op_s1;
		c_s2     <= c_s1;
		d_s2     <= d_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		fl_s2    <= fl_s1;
		g_s2     <= g_s1;
		o_s2     <= o_s1;
		bias_s2  <= bias_s1;
		bprod_s2 <= diff_s1 * $signed({1'b0, w_q});
		ce_s2    <= $signed({bl_s1[31], bl_s1}) - $signed({mean[31], mean});
		lp_s2    <= 64'(wt_s1) * 64'(bl_s1);
	end

	// stage 3: blend result, square, normalize multiply, logit accumulate
	logic signed [33:0] b34;
	logic signed [31:0] blend_val;
	logic [31:0]        abs_ce;
	logic signed [63:0] acc_new;
	always_comb begin
		b34       = 34'(fl_s2) + 34'(bprod_s2 >>> 16);
		blend_val = b34[31:0];
		abs_ce    = ce_s2[32] ? 32'(-ce_s2) : ce_s2[31:0];
		acc_new   = (first_s2 ? 64'(bias_s2) : acc_q) + (lp_s2 >>> 16);
	end

	always_ff @(posedge clk) begin
		op_s3 <= op_s2;
		c_s3  <= c_s2;
		g_s3  <= g_s2;
		o_s3  <= o_s2;
		sq_s3 <= 64'(abs_ce) * 64'(abs_ce);
		p1_s3 <= ce_s2 * $signed({1'b0, inv_q});
		if (v_s2 && op_s2 == PASS_LOGIT) begin
			acc_q <= acc_new;
			if (last_s2) logit_mem[d_s2] <= sat32(acc_new);
		end
		if (cmd.arg_rd) lg_rd_q <= logit_mem[cmd.arg_idx[LW-1:0]];
	end

	// stage 4: second normalize multiply on the low half
	logic signed [42:0] y_s3;
	assign y_s3 = 43'(p1_s3 >>> 16);

	always_ff @(posedge clk) begin
		op_s4 <= op_s3;
		c_s4  <= c_s3;
		g_s4  <= g_s3;
		o_s4  <= o_s3;
		yh_s4 <= 27'(y_s3 >>> 16);
		p2_s4 <= $signed({1'b0, y_s3[15:0]}) * g_s3;
	end

	// stage 5: high half, offset and saturation
	logic signed [63:0] norm_full;
	assign norm_full = (64'(yh_s4) * 64'(g_s4)) + 64'(p2_s4 >>> 16) + 64'(o_s4);

	// blend buffer: read at stage 1, written by blend or normalize
	always_ff @(posedge clk) begin
		bl_s1 <= blend_mem[rc];
		if (v_s2 && op_s2 == PASS_BLEND) blend_mem[c_s2] <= blend_val;
		else if (v_s4 && op_s4 == PASS_NORM) blend_mem[c_s4] <= sat32(norm_full);
	end

	// running sums
	always_ff @(posedge clk) begin
		if (cmd.clamp) begin
			sum_q   <= '0;
			sumsq_q <= '0;
		end else begin
			if (v_s2 && op_s2 == PASS_BLEND) sum_q <= sum_q + 41'(blend_val);
			if (v_s3 && op_s3 == PASS_VAR) sumsq_q <= sumsq_q + (sq_s3 >> 16);
		end
	end

	// arg-max and mixed-radix packing
	logic [3:0]         best_q;
	logic [TOKEN_W-1:0] token_q;
	logic [16:0]        base_q;

	always_ff @(posedge clk) begin
		if (cmd.load_pos) begin
			token_q <= '0;
			base_q  <= 17'd1;
			best_q  <= '0;
		end
		if (cmd.arg_cmp && (cmd.arg_i == 5'd0 || lg_rd_q > best_val_q)) begin
			best_q     <= cmd.arg_i[3:0];
			best_val_q <= lg_rd_q;
		end
		if (cmd.arg_lvl_end) begin
			token_q <= token_q + TOKEN_W'(best_q * base_q);
			base_q  <= 17'(base_q * eff_lvl);
			best_q  <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (cmd.emit) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) m_tdata <= {4'b0, t_q, token_q};
	end

	always_comb begin
		st.num_pos    = num_q > 26'sd0;
		st.div_done   = div_done;
		st.div_busy   = div_busy;
		st.sqrt_done  = sq_done;
		st.sqrt_busy  = sq_busy;
		st.out_busy   = m_tvalid && !m_tready;
		st.level_size = eff_lvl;
	end
endmodule

@@ tb/sv/tb_interpolating_fsq_token_head.sv @@
`timescale 1ns / 1ps

module tb_interpolating_fsq_token_head;
	import fsq_pkg::*;

	localparam int CYCLE_LIMIT = 25000000;
	localparam int RANDOM_WORDS = 100;
	localparam int HOLD_CYCLES = 80000;
	localparam int SETTLE = 40;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [IN_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	interpolating_fsq_token_head dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	typedef struct {
		logic [15:0] token;
		logic [11:0] pos;
	} token_word_t;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  kind;
		logic [1:0]  sel;
		int          row;
		int          col;
		int          word;
		int          pos;
		bit          typed;
		int          token;
	} step_t;

	// shadow copy of the block's storage and registers
	int frame_mem [0:MAX_FRAMES*MODEL_WIDTH-1];
	int gain_mem [0:MODEL_WIDTH-1];
	int offset_mem [0:MODEL_WIDTH-1];
	int bias_mem [0:MAX_LOGITS-1];
	int weight_mem [0:MAX_LOGITS*MODEL_WIDTH-1];
	logic [10:0] reg_frames = 11'd1;
	logic [12:0] reg_tokens = 13'd1;
	logic [4:0] reg_levels [0:3] = '{5'd1, 5'd1, 5'd1, 5'd1};

	token_word_t pending_tokens[$];
	int errors = 0;
	int tokens_seen = 0;
	int cycles = 0;
	bit hold_asked = 0;
	bit hold_done = 0;

	function automatic longint clip32(input longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	// bitwise integer square root, floor
	function automatic longint unsigned root_floor(input longint unsigned x);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= r + bitv) begin
				x -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	// token code for position t under the current registers and tables
	function automatic logic [15:0] predict_token(input logic [11:0] t);
		longint s, n, num, den, left, right, w, sum, mean, ce, y, acc, lv_l, lv_r;
		longint unsigned sumsq, variance, inv, a, hi, lo;
		int blend_v [0:MODEL_WIDTH-1];
		int logit_v [0:MAX_LOGITS-1];
		int size, best, idx, offs, best_val;
		bit have;
		logic [31:0] token, base;
		s = reg_frames;
		n = reg_tokens;
		if (s < 1) s = 1;
		if (s > MAX_FRAMES) s = MAX_FRAMES;
		if (n < 1) n = 1;
		num = (2 * longint'(t) + 1) * s - n;
		den = 2 * n;
		if (num <= 0) begin
			left = 0;
			w = 0;
		end else begin
			left = num / den;
			w = ((num % den) * 65536) / den;
		end
		if (left >= s - 1) begin
			left = s - 1;
			w = 0;
		end
		right = (left + 1 < s - 1) ? left + 1 : s - 1;
		// resample
		sum = 0;
		for (int c = 0; c < MODEL_WIDTH; c++) begin
			lv_l = frame_mem[left * MODEL_WIDTH + c];
			lv_r = frame_mem[right * MODEL_WIDTH + c];
			blend_v[c] = int'((lv_l * (65536 - w) + lv_r * w) >>> 16);
			sum += blend_v[c];
		end
		mean = sum >>> 9;
		// deviation
		sumsq = 0;
		for (int c = 0; c < MODEL_WIDTH; c++) begin
			ce = longint'(blend_v[c]) - mean;
			a = ce < 0 ? longint'(-ce) : ce;
			hi = a >> 16;
			lo = a & 64'hFFFF;
			sumsq += ((hi * hi) << 16) + 2 * hi * lo + ((lo * lo) >> 16);
		end
		variance = sumsq / MODEL_WIDTH + 1;
		inv = root_floor((64'd1 << 48) / variance);
		// normalize, gain, offset
		for (int c = 0; c < MODEL_WIDTH; c++) begin
			ce = longint'(blend_v[c]) - mean;
			y = (ce * longint'(inv)) >>> 16;
			blend_v[c] = int'(clip32(((y * longint'(gain_mem[c])) >>> 16) + offset_mem[c]));
		end
		// linear head
		for (int d = 0; d < MAX_LOGITS; d++) begin
			acc = bias_mem[d];
			for (int c = 0; c < MODEL_WIDTH; c++)
				acc += (longint'(weight_mem[d * MODEL_WIDTH + c]) * longint'(blend_v[c])) >>> 16;
			logit_v[d] = int'(clip32(acc));
		end
		// per-digit arg-max, lower index wins ties
		token = 0;
		base = 1;
		offs = 0;
		for (int lv = 0; lv < LEVEL_COUNT; lv++) begin
			size = reg_levels[lv];
			if (size < 1) size = 1;
			if (size > 16) size = 16;
			best = 0;
			best_val = 32'sh80000000;
			have = 0;
			if (offs < MAX_LOGITS) begin
				best_val = logit_v[offs];
				have = 1;
			end
			for (int i = 1; i < size; i++) begin
				idx = offs + i;
				if (idx >= MAX_LOGITS)
					break;
				if (!have || logit_v[idx] > best_val) begin
					best_val = logit_v[idx];
					best = i;
					have = 1;
				end
			end
			token += best * base;
			base *= size;
			offs += size;
		end
		return token[15:0];
	endfunction

	// update shadow state for an accepted word; queue a token where one is due
	task automatic absorb_word(input logic [1:0] kind, input logic [1:0] sel,
			input int row, input int col, input int word, input int pos,
			input bit typed, input int token);
		token_word_t e;
		case (kind)
			KIND_TABLE: begin
				case (sel)
					SEL_GAIN: gain_mem[col] = word;
					SEL_OFFSET: offset_mem[col] = word;
					SEL_BIAS: if (row < MAX_LOGITS) bias_mem[row] = word;
					default: if (row < MAX_LOGITS) weight_mem[row * MODEL_WIDTH + col] = word;
				endcase
			end
			KIND_FRAME: frame_mem[row * MODEL_WIDTH + col] = word;
			KIND_TOKEN: begin
				e.token = typed ? token[15:0] : predict_token(pos[11:0]);
				e.pos = pos[11:0];
				pending_tokens.insert(pending_tokens.size(), e);
			end
			default: ;
		endcase
	endtask

	// offer one word, with a random gap in front
	task automatic send_word(input logic [1:0] kind, input logic [1:0] sel,
			input int row, input int col, input int word, input int pos,
			input bit typed = 0, input int token = 0);
		int r, gap;
		r = $urandom_range(0, 99);
		gap = r < 75 ? 0 : (r < 96 ? $urandom_range(1, 3) : $urandom_range(8, 40));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {sel, kind};
		s_tdata <= {1'b0, pos[11:0], word[31:0], col[8:0], row[9:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		absorb_word(kind, sel, row, col, word, pos, typed, token);
	endtask

	task automatic drain_tokens();
		s_tvalid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		drain_tokens();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FRAMES: reg_frames = value[10:0];
			CFG_TOKENS: reg_tokens = value[12:0];
			default: reg_levels[2'(idx - CFG_LEVEL0)] = value[4:0];
		endcase
	endtask

	task automatic flag_mismatch(input string what, input int want, input int got);
		$display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, want, got, cycles);
		errors++;
	endtask

	function automatic int mid_word(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// reset, then clock count guard
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side ready, with random stalls and one long hold-off
	initial begin
		int r;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_asked && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					repeat (r < 95 ? $urandom_range(0, 3) : $urandom_range(10, 60))
						@(posedge clk);
				end
			end
		end
	end

	// compare each token word with the oldest pending one
	always @(posedge clk) begin
		token_word_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_tokens.size() == 0) begin
				flag_mismatch("unexpected token word", 0, int'(m_tdata));
			end else begin
				e = pending_tokens.pop_front();
				if (m_tdata[15:0] !== e.token)
					flag_mismatch("token_code", e.token, m_tdata[15:0]);
				if (m_tdata[27:16] !== e.pos)
					flag_mismatch("echoed_position", e.pos, m_tdata[27:16]);
				tokens_seen++;
			end
		end
	end

	initial begin
		step_t steps[$];
		step_t st;
		int kind, sel, row, col, word, r;
		@(posedge arst_n);
		@(posedge clk);

		// fill every entry a token can read: tables, frames 0..7 and 1023
		for (int c = 0; c < MODEL_WIDTH; c++) begin
			send_word(KIND_TABLE, SEL_GAIN, 0, c, 65536 + mid_word(32768), 0);
			send_word(KIND_TABLE, SEL_OFFSET, 0, c, mid_word(65536), 0);
		end
		for (int d = 0; d < MAX_LOGITS; d++)
			send_word(KIND_TABLE, SEL_BIAS, d, 0, mid_word(1 << 18), 0);
		for (int d = 0; d < MAX_LOGITS; d++)
			for (int c = 0; c < MODEL_WIDTH; c++)
				send_word(KIND_TABLE, SEL_WEIGHT, d, c, mid_word(1 << 16), 0);
		for (int f = 0; f < 9; f++)
			for (int c = 0; c < MODEL_WIDTH; c++)
				send_word(KIND_FRAME, 2'd0, f == 8 ? 1023 : f, c, mid_word(1 << 20), 0);

		// directed: reset registers, field extremes, ignored words, register extremes
		steps = '{
			'{0, KIND_TOKEN, 0, 0, 0, 0, 0, 1, 0},
			'{0, KIND_TOKEN, 0, 0, 0, 0, 4095, 1, 0},
			'{0, KIND_UNUSED, 3, 1023, 511, -1, 4095, 0, 0},
			'{0, KIND_TABLE, SEL_BIAS, 1023, 511, 32'sh7FFFFFFF, 0, 0, 0},
			'{0, KIND_TABLE, SEL_WEIGHT, 64, 0, 32'sh80000000, 0, 0, 0},
			'{0, KIND_TABLE, SEL_BIAS, 63, 0, 32'sh7FFFFFFF, 0, 0, 0},
			'{0, KIND_TABLE, SEL_GAIN, 0, 511, 32'sh80000000, 0, 0, 0},
			'{0, KIND_TABLE, SEL_OFFSET, 0, 0, 32'sh7FFFFFFF, 0, 0, 0},
			'{0, KIND_TABLE, SEL_WEIGHT, 63, 511, 32'sh80000000, 0, 0, 0},
			'{0, KIND_FRAME, 0, 1023, 511, 32'sh7FFFFFFF, 0, 0, 0},
			'{0, KIND_FRAME, 0, 0, 0, 32'sh80000000, 0, 0, 0},
			'{0, KIND_TOKEN, 0, 0, 0, 0, 7, 1, 0},
			'{1, 0, 0, 0, CFG_FRAMES, 1024, 0, 0, 0},
			'{1, 0, 0, 0, CFG_TOKENS, 1, 0, 0, 0},
			'{1, 0, 0, 0, CFG_LEVEL0, 16, 0, 0, 0},
			'{1, 0, 0, 0, CFG_LEVEL1, 16, 0, 0, 0},
			'{1, 0, 0, 0, CFG_LEVEL2, 16, 0, 0, 0},
			'{1, 0, 0, 0, CFG_LEVEL3, 16, 0, 0, 0},
			'{0, KIND_TOKEN, 0, 0, 0, 0, 1, 0, 0},
			'{0, KIND_TOKEN, 0, 0, 0, 0, 4095, 0, 0},
			'{1, 0, 0, 0, CFG_FRAMES, 2047, 0, 0, 0},
			'{1, 0, 0, 0, CFG_TOKENS, 4096, 0, 0, 0},
			'{1, 0, 0, 0, CFG_LEVEL0, 0, 0, 0, 0},
			'{1, 0, 0, 0, CFG_LEVEL1, 31, 0, 0, 0},
			'{1, 0, 0, 0, CFG_LEVEL2, 5, 0, 0, 0},
			'{1, 0, 0, 0, CFG_LEVEL3, 3, 0, 0, 0},
			'{0, KIND_TOKEN, 0, 0, 0, 0, 0, 0, 0},
			'{0, KIND_TOKEN, 0, 0, 0, 0, 4095, 0, 0}
		};
		foreach (steps[i]) begin
			st = steps[i];
			if (st.is_cfg)
				write_reg(st.col[CFG_IDX_W-1:0], st.word);
			else
				send_word(st.kind, st.sel, st.row, st.col, st.word, st.pos, st.typed, st.token);
		end

		// random words; small frame grids so every read hits a loaded frame
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 25 == 0) begin
				write_reg(CFG_FRAMES, $urandom_range(0, 8));
				write_reg(CFG_TOKENS, $urandom_range(0, 8191));
				for (int lv = 0; lv < LEVEL_COUNT; lv++)
					write_reg(CFG_IDX_W'(int'(CFG_LEVEL0) + lv), $urandom_range(0, 31));
			end
			if (i == 50)
				hold_asked = 1;
			r = (i >= 50 && i < 54) ? 0 : $urandom_range(0, 99);
			word = $urandom_range(0, 3) == 0 ? int'($urandom) : mid_word(1 << 18);
			col = $urandom_range(0, 511);
			if (r < 22) begin
				send_word(KIND_TOKEN, 2'($urandom_range(0, 3)), $urandom_range(0, 1023), col,
					int'($urandom), $urandom_range(0, 4095));
			end else if (r < 27) begin
				send_word(KIND_UNUSED, 2'($urandom_range(0, 3)), $urandom_range(0, 1023), col,
					int'($urandom), $urandom_range(0, 4095));
			end else if (r < 55) begin
				row = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 7);
				send_word(KIND_FRAME, 2'($urandom_range(0, 3)), row, col, word,
					$urandom_range(0, 4095));
			end else begin
				sel = $urandom_range(0, 3);
				row = $urandom_range(0, 4) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 63);
				if (sel == SEL_GAIN && word[31] == 1'b0 && $urandom_range(0, 1))
					word = 65536 + mid_word(32768);
				send_word(KIND_TABLE, 2'(sel), row, col, word, $urandom_range(0, 4095));
			end
		end

		drain_tokens();
		$display("Covered table, frame and ignored words, register extremes and %0d token words,",
			tokens_seen);
		$display("with random stalls on both sides and one long output hold-off.");
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
